>>> hdl/pcss_pkg.sv
// Shared types, action codes and the duty pattern table for the pulse channel.
// No dependencies; every other file refers to it by scoped names.
package pcss_pkg;

   typedef enum logic [3:0] {
      ACT_TICK         = 4'd0,
      ACT_SWEEP_CLOCK  = 4'd1,
      ACT_DUTY_WRITE   = 4'd2,
      ACT_SWEEP_WRITE  = 4'd3,
      ACT_PERIOD_LOW   = 4'd4,
      ACT_PERIOD_HIGH  = 4'd5,
      ACT_RELOAD_COUNT = 4'd6,
      ACT_RESTART_STEP = 4'd7,
      ACT_CLEAR        = 4'd8
   } action_type;

   localparam int PERIOD_W = 11;
   localparam int TARGET_W = 16;

   localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'h7FF;
   localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd8;

   // sweep setting fields
   localparam int SWEEP_ENABLE_BIT = 7;
   localparam int SWEEP_NEGATE_BIT = 3;

   // one row per duty select, bit index is the duty step
   localparam logic [7:0] DUTY_TABLE [4] = '{
      8'b0000_0010,
      8'b0000_0110,
      8'b0001_1110,
      8'b1111_1001
   };

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [TARGET_W-1:0] target;
      logic [3:0]          div_count;
      logic [3:0]          div_period;
      logic                reload_pending;
   } sweep_type;

   typedef struct packed {
      logic                level;
      logic                muted;
      logic [PERIOD_W-1:0] period;
   } result_type;

   function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
      logic [7:0] row;
      row = DUTY_TABLE[sel];
      return row[step];
   endfunction

endpackage

>>> hdl/pcss_sweep.sv
// Sweep unit: divider step, target period and write-back decision for one sweep clock.
// Depends on pcss_pkg.
module pcss_sweep (
   input  logic [10:0]       period,
   input  logic [7:0]        setting,
   input  logic [3:0]        div_count,
   input  logic [3:0]        div_period,
   input  logic              reload_pending,
   input  logic [15:0]       target,
   input  logic              negate_twos,
   output pcss_pkg::sweep_type sweep_next
);

   logic [2:0]  shift;
   logic [3:0]  count_next;
   logic        fire;
   logic [10:0] part;
   logic [15:0] target_calc;
   logic        write_back;

   assign shift      = setting[2:0];
   assign count_next = div_count + 4'd1;
   assign fire       = count_next >= div_period;
   assign part       = period >> shift;

   always_comb begin
      if (setting[pcss_pkg::SWEEP_NEGATE_BIT]) begin
         target_calc = {5'd0, period} - {5'd0, part} - {15'd0, ~negate_twos};
      end else begin
         target_calc = {5'd0, period} + {5'd0, part};
      end
   end

   assign write_back = setting[pcss_pkg::SWEEP_ENABLE_BIT] && (shift != 3'd0) &&
                       (period >= pcss_pkg::PERIOD_MIN) &&
                       (target_calc <= {5'd0, pcss_pkg::PERIOD_MAX});

   always_comb begin
      sweep_next.period         = period;
      sweep_next.target         = target;
      sweep_next.div_count      = count_next;
      sweep_next.div_period     = div_period;
      sweep_next.reload_pending = reload_pending;
      if (fire) begin
         sweep_next.div_count = 4'd0;
         sweep_next.target    = target_calc;
         if (write_back) begin
            sweep_next.period = target_calc[10:0];
         end
      end
      // a pending reload wins over the divider step
      if (reload_pending) begin
         sweep_next.div_period     = {1'b0, setting[6:4]} + 4'd1;
         sweep_next.div_count      = 4'd0;
         sweep_next.reload_pending = 1'b0;
      end
   end

endmodule

>>> hdl/pcss_core.sv
// Channel state registers and the per-beat update, with the muted level for the result.
// Depends on pcss_pkg and pcss_sweep.
module pcss_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 apply,
   input  logic [3:0]           action,
   input  logic [7:0]           data_byte,
   input  logic                 negate_twos,
   output pcss_pkg::result_type result_in
);

   logic [1:0]  duty_select_ff,    duty_select_in;
   logic [7:0]  sweep_setting_ff,  sweep_setting_in;
   logic [10:0] timer_period_ff,   timer_period_in;
   logic [10:0] countdown_ff,      countdown_in;
   logic [2:0]  duty_step_ff,      duty_step_in;
   logic [15:0] sweep_target_ff,   sweep_target_in;
   logic        reload_pending_ff, reload_pending_in;
   logic [3:0]  div_count_ff,      div_count_in;
   logic [3:0]  div_period_ff,     div_period_in;

   pcss_pkg::sweep_type sweep_next;
   logic                muted;

   pcss_sweep u_sweep (
      .period         (timer_period_ff),
      .setting        (sweep_setting_ff),
      .div_count      (div_count_ff),
      .div_period     (div_period_ff),
      .reload_pending (reload_pending_ff),
      .target         (sweep_target_ff),
      .negate_twos    (negate_twos),
      .sweep_next     (sweep_next)
   );

   always_comb begin
      duty_select_in    = duty_select_ff;
      sweep_setting_in  = sweep_setting_ff;
      timer_period_in   = timer_period_ff;
      countdown_in      = countdown_ff;
      duty_step_in      = duty_step_ff;
      sweep_target_in   = sweep_target_ff;
      reload_pending_in = reload_pending_ff;
      div_count_in      = div_count_ff;
      div_period_in     = div_period_ff;
      case (pcss_pkg::action_type'(action))
         pcss_pkg::ACT_TICK: begin
            if (countdown_ff == 11'd0) begin
               countdown_in = timer_period_ff;
               duty_step_in = duty_step_ff + 3'd1;
            end else begin
               countdown_in = countdown_ff - 11'd1;
            end
         end
         pcss_pkg::ACT_SWEEP_CLOCK: begin
            timer_period_in   = sweep_next.period;
            sweep_target_in   = sweep_next.target;
            div_count_in      = sweep_next.div_count;
            div_period_in     = sweep_next.div_period;
            reload_pending_in = sweep_next.reload_pending;
         end
         pcss_pkg::ACT_DUTY_WRITE:   duty_select_in = data_byte[7:6];
         pcss_pkg::ACT_SWEEP_WRITE: begin
            sweep_setting_in  = data_byte;
            reload_pending_in = 1'b1;
         end
         pcss_pkg::ACT_PERIOD_LOW:   timer_period_in = {timer_period_ff[10:8], data_byte};
         pcss_pkg::ACT_PERIOD_HIGH:  timer_period_in = {data_byte[2:0], timer_period_ff[7:0]};
         pcss_pkg::ACT_RELOAD_COUNT: countdown_in = timer_period_ff;
         pcss_pkg::ACT_RESTART_STEP: duty_step_in = 3'd0;
         pcss_pkg::ACT_CLEAR: begin
            countdown_in      = 11'd0;
            sweep_target_in   = 16'd0;
            duty_step_in      = 3'd0;
            reload_pending_in = 1'b0;
         end
         default: ;
      endcase
   end

   // the result reflects the state after this beat's action
   assign muted = (timer_period_in < pcss_pkg::PERIOD_MIN) ||
                  (!sweep_setting_in[pcss_pkg::SWEEP_NEGATE_BIT] &&
                   (sweep_target_in > {5'd0, pcss_pkg::PERIOD_MAX}));

   always_comb begin
      result_in.muted  = muted;
      result_in.level  = !muted && pcss_pkg::duty_bit(duty_select_in, duty_step_in);
      result_in.period = timer_period_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_select_ff    <= '0;
         sweep_setting_ff  <= '0;
         timer_period_ff   <= '0;
         countdown_ff      <= '0;
         duty_step_ff      <= '0;
         sweep_target_ff   <= '0;
         reload_pending_ff <= 1'b0;
         div_count_ff      <= '0;
         div_period_ff     <= '0;
      end else if (apply) begin
         duty_select_ff    <= duty_select_in;
         sweep_setting_ff  <= sweep_setting_in;
         timer_period_ff   <= timer_period_in;
         countdown_ff      <= countdown_in;
         duty_step_ff      <= duty_step_in;
         sweep_target_ff   <= sweep_target_in;
         reload_pending_ff <= reload_pending_in;
         div_count_ff      <= div_count_in;
         div_period_ff     <= div_period_in;
      end
   end

endmodule

>>> hdl/pulse_channel_sweep_sequencer_unit.sv
// Pulse channel with frequency sweep: input register, channel core, result register.
// An accepted req beat reaches its rsp beat through the input register and then the result register.
// Throughput: one beat per cycle unless rsp_tready stalls the result register; the channel
// state updates in the cycle a beat moves from the input register into the result register.
// Reset (synchronous, active high) zeroes all channel state, the csr bit and both valid flags.
// Depends on pcss_pkg, pcss_core and pcss_sweep.
module pulse_channel_sweep_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   // configuration: negate_twos_complement
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [3:0] action, [11:4] data_byte, [15:12] zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] level, [1] muted, [12:2] period_now, [15:13] zero
);

   logic        negate_ff;
   logic        in_valid_ff;
   logic [3:0]  in_action_ff;
   logic [7:0]  in_data_ff;
   logic        out_valid_ff;
   pcss_pkg::result_type out_result_ff;
   pcss_pkg::result_type result_in;

   logic advance;
   logic apply;

   // the result register frees up when empty or when its beat is taken
   assign advance    = !out_valid_ff || rsp_tready;
   // a stalled input register holds until the result register can take its beat
   assign req_tready = !in_valid_ff || advance;
   assign apply      = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         negate_ff <= 1'b0;
      end else if (csr_wr_en) begin
         negate_ff <= csr_wr_data;
      end
   end

   // input register: valid is control, payload loads on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tdata[3:0];
         in_data_ff   <= req_tdata[11:4];
      end
   end

   pcss_core u_core (
      .clock       (clock),
      .reset       (reset),
      .apply       (apply),
      .action      (in_action_ff),
      .data_byte   (in_data_ff),
      .negate_twos (negate_ff),
      .result_in   (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (apply) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_result_ff.period, out_result_ff.muted, out_result_ff.level};

endmodule

>>> bench/pulse_channel_sweep_sequencer_unit_test.sv
// Self-checking bench for pulse_channel_sweep_sequencer_unit: directed and random beats, random
// idling on both streams, and a cycle-free channel predictor that is checked field by field.
// Depends on pcss_pkg and the unit under test.
module pulse_channel_sweep_sequencer_unit_test;

   // one request beat, packed exactly as it sits in req_tdata[11:0]
   typedef struct packed {
      logic [7:0] data_byte;
      logic [3:0] action;
   } channel_item;

   // action codes the block leaves without effect
   localparam logic [3:0] SPARE_ACTION_LO = 4'(pcss_pkg::ACT_CLEAR) + 4'd1;
   localparam logic [3:0] SPARE_ACTION_HI = 4'hF;

   // duty waveforms, one row per duty select, bit index is the step
   localparam logic [7:0] WAVE_ROWS [4] = '{
      8'b0000_0010, 8'b0000_0110, 8'b0001_1110, 8'b1111_1001
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   pulse_channel_sweep_sequencer_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Channel state as the predictor sees it
   logic                          twos_mode;
   logic [1:0]                    duty_sel;
   logic [7:0]                    sweep_cfg;
   logic [pcss_pkg::PERIOD_W-1:0] period_reg;
   logic [pcss_pkg::PERIOD_W-1:0] countdown_reg;
   logic [2:0]                    step_reg;
   logic [pcss_pkg::TARGET_W-1:0] target_reg;
   logic                          reload_flag;
   logic [3:0]                    div_count;
   logic [3:0]                    div_period;

   channel_item          queued_beats[$];      // waiting to be driven
   pcss_pkg::result_type pending_results[$];   // predicted, not yet seen on rsp
   channel_item          driven_beat;          // beat currently on req_tdata
   pcss_pkg::result_type want;
   int          fail_count = 0;
   int          send_pause = 0;
   int          stall_left = 0;
   bit          gaps_on = 0;
   bit          stalls_on = 0;

   // Run one sweep clock through the divider; fire computes and maybe writes back the target.
   function automatic void clock_sweep_unit();
      logic [3:0]                    next_count;
      logic [2:0]                    shift;
      logic [pcss_pkg::PERIOD_W-1:0] part;
      next_count = div_count + 4'd1;
      shift = sweep_cfg[2:0];
      if (next_count >= div_period) begin
         div_count = '0;
         part = period_reg >> shift;
         if (sweep_cfg[pcss_pkg::SWEEP_NEGATE_BIT])
            target_reg = {5'd0, period_reg} - {5'd0, part} - (twos_mode ? 16'd0 : 16'd1);
         else
            target_reg = {5'd0, period_reg} + {5'd0, part};
         if (sweep_cfg[pcss_pkg::SWEEP_ENABLE_BIT] && shift != 3'd0 && period_reg >= 11'd8 &&
             target_reg <= 16'h07FF)
            period_reg = target_reg[pcss_pkg::PERIOD_W-1:0];
      end else begin
         div_count = next_count;
      end
      // a pending reload wins over whatever the divider just did
      if (reload_flag) begin
         div_period = 4'(sweep_cfg[6:4]) + 4'd1;
         div_count = '0;
         reload_flag = 1'b0;
      end
   endfunction

   // Apply one beat to the predicted channel and return the result it reports.
   function automatic pcss_pkg::result_type apply_channel_beat(input channel_item it);
      pcss_pkg::result_type r;
      logic                 mute;
      case (it.action)
         pcss_pkg::ACT_TICK: begin
            if (countdown_reg == '0) begin
               countdown_reg = period_reg;
               step_reg = step_reg + 3'd1;
            end else begin
               countdown_reg = countdown_reg - 11'd1;
            end
         end
         pcss_pkg::ACT_SWEEP_CLOCK:  clock_sweep_unit();
         pcss_pkg::ACT_DUTY_WRITE:   duty_sel = it.data_byte[7:6];
         pcss_pkg::ACT_SWEEP_WRITE: begin
            sweep_cfg = it.data_byte;
            reload_flag = 1'b1;
         end
         pcss_pkg::ACT_PERIOD_LOW:   period_reg[7:0] = it.data_byte;
         pcss_pkg::ACT_PERIOD_HIGH:  period_reg[10:8] = it.data_byte[2:0];
         pcss_pkg::ACT_RELOAD_COUNT: countdown_reg = period_reg;
         pcss_pkg::ACT_RESTART_STEP: step_reg = '0;
         pcss_pkg::ACT_CLEAR: begin
            countdown_reg = '0;
            target_reg = '0;
            step_reg = '0;
            reload_flag = 1'b0;
         end
         default: ;
      endcase
      // additive overflow mutes only while negate is off
      mute = (period_reg < 11'd8) ||
             (!sweep_cfg[pcss_pkg::SWEEP_NEGATE_BIT] && target_reg > 16'h07FF);
      r.level = mute ? 1'b0 : WAVE_ROWS[duty_sel][step_reg];
      r.muted = mute;
      r.period = period_reg;
      return r;
   endfunction

   // Short pauses dominate; roughly one in ten is long.
   function automatic int pick_pause();
      int roll;
      roll = $urandom_range(99, 0);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(3, 1);
      return $urandom_range(24, 6);
   endfunction

   // Mostly ticks and sweep clocks over short periods, so steps wrap and the sweep fires often.
   function automatic channel_item random_beat();
      channel_item it;
      int          roll;
      roll = $urandom_range(99, 0);
      it.data_byte = 8'($urandom_range(255, 0));
      if (roll < 40) begin
         it.action = pcss_pkg::ACT_TICK;
      end else if (roll < 60) begin
         it.action = pcss_pkg::ACT_SWEEP_CLOCK;
      end else if (roll < 66) begin
         it.action = pcss_pkg::ACT_DUTY_WRITE;
      end else if (roll < 73) begin
         it.action = pcss_pkg::ACT_SWEEP_WRITE;
      end else if (roll < 81) begin
         it.action = pcss_pkg::ACT_PERIOD_LOW;
         if ($urandom_range(1, 0) == 0)
            it.data_byte[7:5] = '0;
      end else if (roll < 88) begin
         it.action = pcss_pkg::ACT_PERIOD_HIGH;
         if ($urandom_range(2, 0) != 0)
            it.data_byte[2:0] = '0;
      end else if (roll < 92) begin
         it.action = pcss_pkg::ACT_RELOAD_COUNT;
      end else if (roll < 95) begin
         it.action = pcss_pkg::ACT_RESTART_STEP;
      end else if (roll < 97) begin
         it.action = pcss_pkg::ACT_CLEAR;
      end else begin
         it.action = 4'($urandom_range(int'(SPARE_ACTION_HI), int'(SPARE_ACTION_LO)));
      end
      return it;
   endfunction

   task automatic queue_beat(input logic [3:0] action, input logic [7:0] data_byte);
      channel_item it;
      it.action = action;
      it.data_byte = data_byte;
      queued_beats.push_back(it);
   endtask

   // Hit every action, the field extremes, additive overflow and the unused codes.
   task automatic queue_directed_beats();
      queue_beat(pcss_pkg::ACT_PERIOD_LOW, 8'hFF);
      queue_beat(pcss_pkg::ACT_PERIOD_HIGH, 8'hFF);     // period 0x7FF
      queue_beat(pcss_pkg::ACT_DUTY_WRITE, 8'hC0);
      queue_beat(pcss_pkg::ACT_SWEEP_WRITE, 8'h81);     // enable, add, shift 1: overflow mutes
      queue_beat(pcss_pkg::ACT_SWEEP_CLOCK, 8'h00);
      queue_beat(pcss_pkg::ACT_TICK, 8'h00);
      queue_beat(pcss_pkg::ACT_RESTART_STEP, 8'h00);
      queue_beat(pcss_pkg::ACT_RELOAD_COUNT, 8'h00);
      queue_beat(pcss_pkg::ACT_SWEEP_WRITE, 8'h79);     // disabled, slow divider, negate
      queue_beat(pcss_pkg::ACT_SWEEP_CLOCK, 8'h00);
      queue_beat(pcss_pkg::ACT_PERIOD_LOW, 8'h00);
      queue_beat(pcss_pkg::ACT_PERIOD_HIGH, 8'h00);     // period 0: muted on period
      queue_beat(pcss_pkg::ACT_SWEEP_CLOCK, 8'h00);     // slow divider counts on without firing
      queue_beat(pcss_pkg::ACT_SWEEP_WRITE, 8'h00);     // back to additive with the target from the earlier sweep
      queue_beat(pcss_pkg::ACT_CLEAR, 8'h00);
      queue_beat(pcss_pkg::ACT_PERIOD_LOW, 8'h08);
      queue_beat(pcss_pkg::ACT_SWEEP_WRITE, 8'h8B);     // enable, negate, shift 3
      queue_beat(pcss_pkg::ACT_SWEEP_CLOCK, 8'h00);
      queue_beat(pcss_pkg::ACT_TICK, 8'h00);
      queue_beat(pcss_pkg::ACT_TICK, 8'h00);
      queue_beat(SPARE_ACTION_LO, 8'hFF);
      queue_beat(SPARE_ACTION_HI, 8'h00);
      queue_beat(pcss_pkg::ACT_DUTY_WRITE, 8'h40);
      queue_beat(pcss_pkg::ACT_DUTY_WRITE, 8'h80);
   endtask

   // Write the negate mode; only called with the channel drained.
   task automatic write_negate_mode(input logic mode);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= mode;
      twos_mode = mode;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Hold until every queued beat is sent and answered, then let the pipe settle.
   // Check on the falling edge so the driver and monitor updates have landed.
   task automatic drain_channel();
      while (queued_beats.size() != 0 || req_tvalid || pending_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Driver: predict on acceptance, then either hold off or present the next beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_pause = 0;
      end else begin
         if (req_tvalid && req_tready)
            pending_results.push_back(apply_channel_beat(driven_beat));
         if (!req_tvalid || req_tready) begin
            if (send_pause > 0) begin
               send_pause--;
               req_tvalid <= 1'b0;
            end else if (queued_beats.size() != 0) begin
               driven_beat = queued_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {4'b0000, driven_beat};
               send_pause = gaps_on ? pick_pause() : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted result beat, then decide on back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result beat, got %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata[0] !== want.level) begin
                  $display("%0t: level expected %0d, got %0d", $time, want.level, rsp_tdata[0]);
                  fail_count++;
               end
               if (rsp_tdata[1] !== want.muted) begin
                  $display("%0t: muted expected %0d, got %0d", $time, want.muted, rsp_tdata[1]);
                  fail_count++;
               end
               if (rsp_tdata[12:2] !== want.period) begin
                  $display("%0t: period expected %h, got %h", $time, want.period,
                           rsp_tdata[12:2]);
                  fail_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = stalls_on ? pick_pause() : 0;
         end
      end
   end

   // Stimulus: reset, directed pass under both negate modes, then random phases.
   initial begin
      twos_mode = 1'b0;
      duty_sel = '0;
      sweep_cfg = '0;
      period_reg = '0;
      countdown_reg = '0;
      step_reg = '0;
      target_reg = '0;
      reload_flag = 1'b0;
      div_count = '0;
      div_period = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      write_negate_mode(1'b0);
      queue_directed_beats();
      drain_channel();

      gaps_on = 1;
      stalls_on = 1;
      write_negate_mode(1'b1);
      queue_directed_beats();
      drain_channel();

      for (int phase = 0; phase < 5; phase++) begin
         // phase 2 runs the sender flat out, phase 1 the receiver
         gaps_on = (phase != 2);
         stalls_on = (phase != 1);
         write_negate_mode(phase == 4 ? 1'($urandom_range(1, 0)) : 1'(phase));
         repeat (200) queued_beats.push_back(random_beat());
         drain_channel();
      end

      if (pending_results.size() != 0)
         fail_count++;
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

endmodule
